>>> design/ctom_pkg.sv
// ----------------------------------------------------------------------------
// ctom_pkg
// Shared constants and codes for the chunked tile occupancy map.
// ----------------------------------------------------------------------------
package ctom_pkg;

   localparam int MAX_SIDE   = 256;
   localparam int CHUNK_SIDE = 16;

   localparam int SIDE_W   = $clog2(MAX_SIDE);
   localparam int CHUNK_W  = $clog2(CHUNK_SIDE);
   localparam int GRID_W   = SIDE_W - CHUNK_W;
   localparam int TILE_AW  = 2 * SIDE_W;
   localparam int CHUNK_AW = 2 * GRID_W;
   localparam int OCC_W    = 2 * CHUNK_W + 1;
   localparam int VER_W    = 32;
   localparam int DIM_W    = 9;
   localparam int POS_W    = 10;
   localparam int AREA_W   = 9;
   localparam int COUNT_W  = 17;
   localparam int TILE_DW  = 3;
   localparam int CHUNK_DW = OCC_W + VER_W;

   localparam logic [2:0] FN_WRITE_KIND = 3'd0;
   localparam logic [2:0] FN_WRITE_MARK = 3'd1;
   localparam logic [2:0] FN_READ_TILE  = 3'd2;
   localparam logic [2:0] FN_READ_VER   = 3'd3;
   localparam logic [2:0] FN_COUNT      = 3'd4;

   localparam logic [1:0] KIND_NONE = 2'd0;
   localparam logic [1:0] KIND_ROCK = 2'd2;

   localparam logic CSR_MAP_WIDTH  = 1'b0;
   localparam logic CSR_MAP_HEIGHT = 1'b1;

   typedef struct packed {
      logic                we;
      logic [TILE_AW-1:0]  waddr;
      logic [TILE_DW-1:0]  wdata;
      logic [TILE_AW-1:0]  raddr;
   } tile_port_type;

   typedef struct packed {
      logic                we;
      logic [CHUNK_AW-1:0] waddr;
      logic [CHUNK_DW-1:0] wdata;
      logic [CHUNK_AW-1:0] raddr;
   } chunk_port_type;

endpackage

>>> design/ctom_ram.sv
// ----------------------------------------------------------------------------
// ctom_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module ctom_ram #(
   parameter int AW = 8,
   parameter int DW = 8
) (
   input  logic          clock,
   input  logic          we,
   input  logic [AW-1:0] waddr,
   input  logic [DW-1:0] wdata,
   input  logic [AW-1:0] raddr,
   output logic [DW-1:0] rdata
);

   logic [DW-1:0] mem [2**AW];
   logic [DW-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

>>> design/ctom_ctrl.sv
// ----------------------------------------------------------------------------
// ctom_ctrl
// Sequencer: clearing sweep, read-modify-write of tile and chunk entries,
// region walk over chunks and tiles, and the result register.
// ----------------------------------------------------------------------------
module ctom_ctrl import ctom_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [2:0]          req_func,
   input  logic signed [POS_W-1:0] req_pos_x,
   input  logic signed [POS_W-1:0] req_pos_y,
   input  logic [1:0]          req_kind,
   input  logic                req_mark_value,
   input  logic [AREA_W-1:0]   req_area_width,
   input  logic [AREA_W-1:0]   req_area_height,
   input  logic [GRID_W-1:0]   req_chunk_col,
   input  logic [GRID_W-1:0]   req_chunk_row,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic                rsp_tile_valid,
   output logic [1:0]          rsp_tile_kind,
   output logic                rsp_tile_marked,
   output logic [COUNT_W-1:0]  rsp_region_count,
   output logic [VER_W-1:0]    rsp_chunk_version_out,
   output logic [VER_W-1:0]    rsp_global_version,
   input  logic                csr_wen,
   input  logic                csr_index,
   input  logic [DIM_W-1:0]    csr_wdata,
   output tile_port_type       tile_port,
   input  logic [TILE_DW-1:0]  tile_rdata,
   output chunk_port_type      chunk_port,
   input  logic [CHUNK_DW-1:0] chunk_rdata
);

   typedef enum logic [3:0] {
      S_CLEAR, S_IDLE, S_ISSUE, S_EXEC, S_CRD, S_CEVAL, S_TRD, S_TACC, S_DONE
   } state_type;

   state_type state_ff, state_in;
   logic [TILE_AW-1:0] clr_ff, clr_in;
   logic [DIM_W-1:0] mapw_ff, mapw_in, maph_ff, maph_in;
   logic [VER_W-1:0] gver_ff, gver_in;

   logic [2:0] func_ff, func_in;
   logic signed [POS_W-1:0] x_ff, x_in, y_ff, y_in;
   logic [1:0] kind_ff, kind_in;
   logic mark_ff, mark_in;
   logic [AREA_W-1:0] aw_ff, aw_in, ah_ff, ah_in;
   logic [GRID_W-1:0] ccol_ff, ccol_in, crow_ff, crow_in;

   logic [DIM_W-1:0] left_ff, left_in, right_ff, right_in;
   logic [DIM_W-1:0] top_ff, top_in, bottom_ff, bottom_in;
   logic [GRID_W-1:0] cx_ff, cx_in, cy_ff, cy_in;
   logic [SIDE_W-1:0] tx_ff, tx_in, ty_ff, ty_in, tx0_ff, tx0_in;
   logic [DIM_W-1:0] txe_ff, txe_in, tye_ff, tye_in;
   logic [COUNT_W-1:0] total_ff, total_in;

   logic res_tv_ff, res_tv_in, res_tm_ff, res_tm_in;
   logic [1:0] res_tk_ff, res_tk_in;
   logic [VER_W-1:0] res_ver_ff, res_ver_in;

   logic rsp_valid_ff, rsp_valid_in;
   logic rsp_tv_ff, rsp_tv_in, rsp_tm_ff, rsp_tm_in;
   logic [1:0] rsp_tk_ff, rsp_tk_in;
   logic [COUNT_W-1:0] rsp_cnt_ff, rsp_cnt_in;
   logic [VER_W-1:0] rsp_cver_ff, rsp_cver_in, rsp_gver_ff, rsp_gver_in;

   logic [DIM_W-1:0] eff_w, eff_h;
   logic on_map;
   logic signed [11:0] lx, ly, rx, ry, ew, eh, rclip, bclip;
   logic [DIM_W-1:0] x0, y0, x0e, y0e, x1, y1, rm1, bm1, tx_nx, ty_nx;
   logic [OCC_W-1:0] occ;
   logic [VER_W-1:0] cver;
   logic [1:0] old_kind;
   logic old_mark;
   logic full_in_region;
   logic last_chunk;

   always_comb begin
      eff_w = (mapw_ff > DIM_W'(MAX_SIDE)) ? DIM_W'(MAX_SIDE) : mapw_ff;
      eff_h = (maph_ff > DIM_W'(MAX_SIDE)) ? DIM_W'(MAX_SIDE) : maph_ff;
      on_map = !x_ff[POS_W-1] && !y_ff[POS_W-1] &&
               (x_ff[DIM_W-1:0] < eff_w) && (y_ff[DIM_W-1:0] < eff_h);
      lx = x_ff[POS_W-1] ? 12'sd0 : $signed({2'b00, x_ff});
      ly = y_ff[POS_W-1] ? 12'sd0 : $signed({2'b00, y_ff});
      rx = $signed({{2{x_ff[POS_W-1]}}, x_ff}) + $signed({3'b000, aw_ff});
      ry = $signed({{2{y_ff[POS_W-1]}}, y_ff}) + $signed({3'b000, ah_ff});
      ew = $signed({3'b000, eff_w});
      eh = $signed({3'b000, eff_h});
      rclip = (rx < ew) ? rx : ew;
      bclip = (ry < eh) ? ry : eh;
      x0 = {1'b0, cx_ff, {CHUNK_W{1'b0}}};
      y0 = {1'b0, cy_ff, {CHUNK_W{1'b0}}};
      x0e = x0 + DIM_W'(CHUNK_SIDE);
      y0e = y0 + DIM_W'(CHUNK_SIDE);
      x1 = (x0e < eff_w) ? x0e : eff_w;
      y1 = (y0e < eff_h) ? y0e : eff_h;
      rm1 = right_ff - 1'b1;
      bm1 = bottom_ff - 1'b1;
      tx_nx = {1'b0, tx_ff} + 1'b1;
      ty_nx = {1'b0, ty_ff} + 1'b1;
      occ = chunk_rdata[CHUNK_DW-1:VER_W];
      cver = chunk_rdata[VER_W-1:0];
      old_kind = tile_rdata[1:0];
      old_mark = tile_rdata[2];
      full_in_region = (left_ff <= x0) && (top_ff <= y0) &&
                       (right_ff >= x1) && (bottom_ff >= y1);
      last_chunk = (cx_ff == rm1[SIDE_W-1:CHUNK_W]) && (cy_ff == bm1[SIDE_W-1:CHUNK_W]);
   end

   always_comb begin
      state_in = state_ff;   clr_in = clr_ff;
      mapw_in = mapw_ff;     maph_in = maph_ff;     gver_in = gver_ff;
      func_in = func_ff;     x_in = x_ff;           y_in = y_ff;
      kind_in = kind_ff;     mark_in = mark_ff;
      aw_in = aw_ff;         ah_in = ah_ff;
      ccol_in = ccol_ff;     crow_in = crow_ff;
      left_in = left_ff;     right_in = right_ff;
      top_in = top_ff;       bottom_in = bottom_ff;
      cx_in = cx_ff;         cy_in = cy_ff;
      tx_in = tx_ff;         ty_in = ty_ff;         tx0_in = tx0_ff;
      txe_in = txe_ff;       tye_in = tye_ff;       total_in = total_ff;
      res_tv_in = res_tv_ff; res_tk_in = res_tk_ff; res_tm_in = res_tm_ff;
      res_ver_in = res_ver_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_tv_in = rsp_tv_ff; rsp_tk_in = rsp_tk_ff; rsp_tm_in = rsp_tm_ff;
      rsp_cnt_in = rsp_cnt_ff; rsp_cver_in = rsp_cver_ff; rsp_gver_in = rsp_gver_ff;

      tile_port.we    = 1'b0;
      tile_port.waddr = clr_ff;
      tile_port.wdata = '0;
      tile_port.raddr = {ty_ff, tx_ff};
      chunk_port.we    = 1'b0;
      chunk_port.waddr = clr_ff[CHUNK_AW-1:0];
      chunk_port.wdata = {{OCC_W{1'b0}}, VER_W'(1)};
      chunk_port.raddr = {cy_ff, cx_ff};

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_CLEAR: begin
            tile_port.we = 1'b1;
            chunk_port.we = (clr_ff[TILE_AW-1:CHUNK_AW] == '0);
            gver_in = '0;
            clr_in = clr_ff + 1'b1;
            if (&clr_ff) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               func_in = req_func;         x_in = req_pos_x;    y_in = req_pos_y;
               kind_in = req_kind;         mark_in = req_mark_value;
               aw_in = req_area_width;     ah_in = req_area_height;
               ccol_in = req_chunk_col;    crow_in = req_chunk_row;
               state_in = S_ISSUE;
            end
         end
         S_ISSUE: begin
            tile_port.raddr = {y_ff[SIDE_W-1:0], x_ff[SIDE_W-1:0]};
            chunk_port.raddr = (func_ff == FN_READ_VER) ? {crow_ff, ccol_ff} :
                               {y_ff[SIDE_W-1:CHUNK_W], x_ff[SIDE_W-1:CHUNK_W]};
            res_tv_in = 1'b0; res_tk_in = KIND_NONE; res_tm_in = 1'b0;
            res_ver_in = '0;  total_in = '0;
            if (func_ff == FN_COUNT) begin
               left_in = lx[DIM_W-1:0];     right_in = rclip[DIM_W-1:0];
               top_in = ly[DIM_W-1:0];      bottom_in = bclip[DIM_W-1:0];
               cx_in = lx[SIDE_W-1:CHUNK_W];
               cy_in = ly[SIDE_W-1:CHUNK_W];
               state_in = (lx >= rclip || ly >= bclip) ? S_DONE : S_CRD;
            end else begin
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            tile_port.waddr = {y_ff[SIDE_W-1:0], x_ff[SIDE_W-1:0]};
            chunk_port.waddr = {y_ff[SIDE_W-1:CHUNK_W], x_ff[SIDE_W-1:CHUNK_W]};
            case (func_ff)
               FN_WRITE_KIND: begin
                  if (kind_ff <= KIND_ROCK && on_map && old_kind != kind_ff) begin
                     tile_port.we = 1'b1;
                     tile_port.wdata = {1'b0, kind_ff};
                     chunk_port.we = 1'b1;
                     chunk_port.wdata = {occ + OCC_W'(kind_ff != KIND_NONE)
                                             - OCC_W'(old_kind != KIND_NONE),
                                         cver + 1'b1};
                     gver_in = gver_ff + 1'b1;
                  end
               end
               FN_WRITE_MARK: begin
                  if (on_map && old_mark != mark_ff) begin
                     tile_port.we = 1'b1;
                     tile_port.wdata = {mark_ff, old_kind};
                     chunk_port.we = 1'b1;
                     chunk_port.wdata = {occ, cver + 1'b1};
                     gver_in = gver_ff + 1'b1;
                  end
               end
               FN_READ_TILE: begin
                  if (on_map) begin
                     res_tv_in = 1'b1; res_tk_in = old_kind; res_tm_in = old_mark;
                  end
               end
               FN_READ_VER: begin
                  if ({1'b0, ccol_ff, {CHUNK_W{1'b0}}} < eff_w &&
                      {1'b0, crow_ff, {CHUNK_W{1'b0}}} < eff_h) begin
                     res_ver_in = cver;
                  end
               end
               default: ;
            endcase
            state_in = S_DONE;
         end
         S_CRD: begin
            state_in = S_CEVAL;
         end
         S_CEVAL: begin
            if (occ != '0 && !full_in_region) begin
               tx_in = (left_ff > x0) ? left_ff[SIDE_W-1:0] : x0[SIDE_W-1:0];
               tx0_in = (left_ff > x0) ? left_ff[SIDE_W-1:0] : x0[SIDE_W-1:0];
               ty_in = (top_ff > y0) ? top_ff[SIDE_W-1:0] : y0[SIDE_W-1:0];
               txe_in = (right_ff < x1) ? right_ff : x1;
               tye_in = (bottom_ff < y1) ? bottom_ff : y1;
               state_in = S_TRD;
            end else begin
               if (occ != '0) begin
                  total_in = total_ff + COUNT_W'(occ);
               end
               if (last_chunk) begin
                  state_in = S_DONE;
               end else if (cx_ff != rm1[SIDE_W-1:CHUNK_W]) begin
                  cx_in = cx_ff + 1'b1;
                  state_in = S_CRD;
               end else begin
                  cx_in = left_ff[SIDE_W-1:CHUNK_W];
                  cy_in = cy_ff + 1'b1;
                  state_in = S_CRD;
               end
            end
         end
         S_TRD: begin
            state_in = S_TACC;
         end
         S_TACC: begin
            total_in = total_ff + COUNT_W'(old_kind != KIND_NONE);
            if (tx_nx < txe_ff) begin
               tx_in = tx_nx[SIDE_W-1:0];
               state_in = S_TRD;
            end else if (ty_nx < tye_ff) begin
               tx_in = tx0_ff;
               ty_in = ty_nx[SIDE_W-1:0];
               state_in = S_TRD;
            end else if (last_chunk) begin
               state_in = S_DONE;
            end else if (cx_ff != rm1[SIDE_W-1:CHUNK_W]) begin
               cx_in = cx_ff + 1'b1;
               state_in = S_CRD;
            end else begin
               cx_in = left_ff[SIDE_W-1:CHUNK_W];
               cy_in = cy_ff + 1'b1;
               state_in = S_CRD;
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_tv_in = res_tv_ff; rsp_tk_in = res_tk_ff; rsp_tm_in = res_tm_ff;
               rsp_cnt_in = (func_ff == FN_COUNT) ? total_ff : '0;
               rsp_cver_in = res_ver_ff;
               rsp_gver_in = gver_ff;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase

      if (csr_wen) begin
         if (csr_index == CSR_MAP_WIDTH) begin
            mapw_in = csr_wdata;
         end else begin
            maph_in = csr_wdata;
         end
         clr_in = '0;
         state_in = S_CLEAR;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         clr_ff <= '0;
         mapw_ff <= DIM_W'(MAX_SIDE);
         maph_ff <= DIM_W'(MAX_SIDE);
         gver_ff <= '0;
         total_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         clr_ff <= clr_in;
         mapw_ff <= mapw_in;
         maph_ff <= maph_in;
         gver_ff <= gver_in;
         total_ff <= total_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      func_ff <= func_in;     x_ff <= x_in;         y_ff <= y_in;
      kind_ff <= kind_in;     mark_ff <= mark_in;
      aw_ff <= aw_in;         ah_ff <= ah_in;
      ccol_ff <= ccol_in;     crow_ff <= crow_in;
      left_ff <= left_in;     right_ff <= right_in;
      top_ff <= top_in;       bottom_ff <= bottom_in;
      cx_ff <= cx_in;         cy_ff <= cy_in;
      tx_ff <= tx_in;         ty_ff <= ty_in;       tx0_ff <= tx0_in;
      txe_ff <= txe_in;       tye_ff <= tye_in;
      res_tv_ff <= res_tv_in; res_tk_ff <= res_tk_in; res_tm_ff <= res_tm_in;
      res_ver_ff <= res_ver_in;
      rsp_tv_ff <= rsp_tv_in; rsp_tk_ff <= rsp_tk_in; rsp_tm_ff <= rsp_tm_in;
      rsp_cnt_ff <= rsp_cnt_in; rsp_cver_ff <= rsp_cver_in; rsp_gver_ff <= rsp_gver_in;
   end

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_tile_valid = rsp_tv_ff;
   assign rsp_tile_kind = rsp_tk_ff;
   assign rsp_tile_marked = rsp_tm_ff;
   assign rsp_region_count = rsp_cnt_ff;
   assign rsp_chunk_version_out = rsp_cver_ff;
   assign rsp_global_version = rsp_gver_ff;

   // tile updates bump the global version by exactly one
   a_gver_bump: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_EXEC && tile_port.we && !csr_wen) |=> gver_ff == $past(gver_ff) + 1'b1)
      else $error("global version not bumped on tile update");

   a_we_states: assert property (@(posedge clock) disable iff (reset)
      tile_port.we |-> (state_ff == S_CLEAR || state_ff == S_EXEC))
      else $error("tile write outside clear or update");

   a_total_bound: assert property (@(posedge clock) disable iff (reset)
      total_ff <= COUNT_W'(MAX_SIDE * MAX_SIDE))
      else $error("region total out of range");

   a_done_load: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DONE && (!rsp_valid_ff || !rsp_stall) && !csr_wen)
         |=> (rsp_valid_ff && state_ff == S_IDLE))
      else $error("finished item not delivered to result register");

endmodule

>>> design/chunked_tile_occupancy_map.sv
// ----------------------------------------------------------------------------
// chunked_tile_occupancy_map
// Tile grid with per-chunk occupancy counters and change versions.
// ----------------------------------------------------------------------------
// After reset and after every map_width or map_height write the block runs a
// clearing sweep over all 65536 entries of the tile RAM (chunk RAM cleared in
// the same sweep) and takes no beat until it ends. Writes, tile reads and
// chunk version reads each go through issue, RAM read, update/write-back and
// result load. A region count reads every touched chunk, and each region tile
// of a partially covered, non-empty chunk one at a time through the single
// read port of the tile RAM. A finished result waits in an output register
// while the next beat is taken.
// ----------------------------------------------------------------------------
module chunked_tile_occupancy_map import ctom_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [2:0]          req_func,
   input  logic signed [POS_W-1:0] req_pos_x,
   input  logic signed [POS_W-1:0] req_pos_y,
   input  logic [1:0]          req_kind,
   input  logic                req_mark_value,
   input  logic [AREA_W-1:0]   req_area_width,
   input  logic [AREA_W-1:0]   req_area_height,
   input  logic [GRID_W-1:0]   req_chunk_col,
   input  logic [GRID_W-1:0]   req_chunk_row,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic                rsp_tile_valid,
   output logic [1:0]          rsp_tile_kind,
   output logic                rsp_tile_marked,
   output logic [COUNT_W-1:0]  rsp_region_count,
   output logic [VER_W-1:0]    rsp_chunk_version_out,
   output logic [VER_W-1:0]    rsp_global_version,
   input  logic                csr_wen,
   input  logic                csr_index,
   input  logic [DIM_W-1:0]    csr_wdata
);

   tile_port_type       tile_port;
   chunk_port_type      chunk_port;
   logic [TILE_DW-1:0]  tile_rdata;
   logic [CHUNK_DW-1:0] chunk_rdata;

   ctom_ram #(.AW(TILE_AW), .DW(TILE_DW)) u_tile_ram (
      .clock (clock),
      .we    (tile_port.we),
      .waddr (tile_port.waddr),
      .wdata (tile_port.wdata),
      .raddr (tile_port.raddr),
      .rdata (tile_rdata)
   );

   ctom_ram #(.AW(CHUNK_AW), .DW(CHUNK_DW)) u_chunk_ram (
      .clock (clock),
      .we    (chunk_port.we),
      .waddr (chunk_port.waddr),
      .wdata (chunk_port.wdata),
      .raddr (chunk_port.raddr),
      .rdata (chunk_rdata)
   );

   ctom_ctrl u_ctrl (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_stall             (req_stall),
      .req_func              (req_func),
      .req_pos_x             (req_pos_x),
      .req_pos_y             (req_pos_y),
      .req_kind              (req_kind),
      .req_mark_value        (req_mark_value),
      .req_area_width        (req_area_width),
      .req_area_height       (req_area_height),
      .req_chunk_col         (req_chunk_col),
      .req_chunk_row         (req_chunk_row),
      .rsp_valid             (rsp_valid),
      .rsp_stall             (rsp_stall),
      .rsp_tile_valid        (rsp_tile_valid),
      .rsp_tile_kind         (rsp_tile_kind),
      .rsp_tile_marked       (rsp_tile_marked),
      .rsp_region_count      (rsp_region_count),
      .rsp_chunk_version_out (rsp_chunk_version_out),
      .rsp_global_version    (rsp_global_version),
      .csr_wen               (csr_wen),
      .csr_index             (csr_index),
      .csr_wdata             (csr_wdata),
      .tile_port             (tile_port),
      .tile_rdata            (tile_rdata),
      .chunk_port            (chunk_port),
      .chunk_rdata           (chunk_rdata)
   );

endmodule
